>>> rtl/ft12_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ft12_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VAR = 2'd2;

    localparam logic [9:0]  MAX_LEN_RST = 10'd512;
    localparam logic [15:0] TIMEOUT_RST = 16'd10;
    localparam logic [8:0]  MIN_VAR_RST = 9'd14;

    // item kinds
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // result codes
    localparam logic [2:0] ST_PENDING       = 3'd0;
    localparam logic [2:0] ST_FIXED_OK      = 3'd1;
    localparam logic [2:0] ST_VAR_OK        = 3'd2;
    localparam logic [2:0] ST_BAD_FIXED     = 3'd3;
    localparam logic [2:0] ST_OVERFLOW      = 3'd4;
    localparam logic [2:0] ST_TIMEOUT_DATA  = 3'd5;
    localparam logic [2:0] ST_TIMEOUT_EMPTY = 3'd6;

    // frame framing bytes
    localparam logic [7:0] START_FIXED = 8'h10;
    localparam logic [7:0] START_VAR   = 8'h68;
    localparam logic [7:0] STOP_BYTE   = 8'h16;

    localparam int         HDR_BYTES    = 4;
    localparam logic [9:0] HDR_COUNT    = 10'd4;
    localparam logic [10:0] FIXED_LEN   = 11'd5;
    localparam logic [10:0] VAR_OVERHEAD = 11'd6;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
    } t_in_word;

    typedef struct packed {
        logic [2:0] status;
        logic [9:0] frame_len;
    } t_out_word;

    typedef struct packed {
        logic [9:0]  max_len;
        logic [15:0] timeout_ticks;
        logic [8:0]  min_variable_len;
    } t_cfg;

endpackage

`default_nettype wire

>>> rtl/ft12_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module ft12_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [ft12_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ft12_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output ft12_pkg::t_cfg                      o_cfg
);
    import ft12_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_len          <= MAX_LEN_RST;
            r_cfg.timeout_ticks    <= TIMEOUT_RST;
            r_cfg.min_variable_len <= MIN_VAR_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAX_LEN: r_cfg.max_len          <= i_cfg_data[9:0];
                CFG_TIMEOUT: r_cfg.timeout_ticks    <= i_cfg_data[15:0];
                CFG_MIN_VAR: r_cfg.min_variable_len <= i_cfg_data[8:0];
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/ft12_in_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module ft12_in_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire ft12_pkg::t_in_word i_word,
    output logic                   o_valid,
    input  wire logic              i_take,
    output ft12_pkg::t_in_word     o_word
);
    import ft12_pkg::*;

    logic     r_valid;
    t_in_word r_word;

    // slot frees up in the same cycle the engine takes the held word
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= i_word;
        end
    end

endmodule

`default_nettype wire

>>> rtl/ft12_frame_engine.sv
`timescale 1ns / 1ps
`default_nettype none

module ft12_frame_engine #(
    parameter int MAX_BYTES = 512
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ft12_pkg::t_cfg     i_cfg,
    input  wire logic               i_valid,
    output logic                    o_take,
    input  wire ft12_pkg::t_in_word i_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output ft12_pkg::t_out_word     o_out_word
);
    import ft12_pkg::*;

    localparam int LIM_BITS = $clog2(MAX_BYTES + 1);
    localparam int LIM_W    = (LIM_BITS > 11) ? LIM_BITS : 11;
    localparam logic [LIM_W-1:0] MAX_LIM = LIM_W'(MAX_BYTES);

    logic [9:0]  r_count, n_count;
    logic [7:0]  r_hdr [HDR_BYTES];
    logic [7:0]  n_hdr [HDR_BYTES];
    logic [7:0]  r_sum, n_sum;
    logic [7:0]  r_sum1, n_sum1;
    logic [7:0]  r_sum2, n_sum2;
    logic [7:0]  r_prev, n_prev;
    logic [15:0] r_tick, n_tick;

    logic        r_out_valid;
    t_out_word   r_out_word;
    t_out_word   res;

    logic        fire;
    logic [7:0]  rx;
    logic [10:0] byte_n;
    logic [16:0] tick_n;
    logic        tick_expired;
    logic [7:0]  fixed_sum;
    logic        fixed_hit;
    logic        var_hit;
    logic [LIM_W-1:0] limit;
    logic        ovf;
    logic        terminal;

    assign o_take = !r_out_valid || i_out_ready;
    assign fire   = i_valid && o_take;
    assign rx     = i_word.rx_byte;

    assign byte_n       = {1'b0, r_count} + 11'd1;
    assign tick_n       = {1'b0, r_tick} + 17'd1;
    assign tick_expired = tick_n > {1'b0, i_cfg.timeout_ticks};
    assign fixed_sum    = r_hdr[1] + r_hdr[2];

    // header bytes are all stored by the time either check can pass
    assign fixed_hit = (byte_n == FIXED_LEN) && (r_hdr[0] == START_FIXED)
                       && (rx == STOP_BYTE);
    assign var_hit = (byte_n >= {2'b00, i_cfg.min_variable_len})
                     && (r_hdr[0] == START_VAR) && (r_hdr[1] == r_hdr[2])
                     && (r_hdr[3] == START_VAR)
                     && (byte_n == VAR_OVERHEAD + {3'b000, r_hdr[1]})
                     && (rx == STOP_BYTE) && (r_sum1 == r_prev);

    assign limit = (LIM_W'(i_cfg.max_len) < MAX_LIM) ? LIM_W'(i_cfg.max_len) : MAX_LIM;
    assign ovf   = LIM_W'(byte_n) >= limit;

    always_comb begin
        n_count  = r_count;
        n_hdr    = r_hdr;
        n_sum    = r_sum;
        n_sum1   = r_sum1;
        n_sum2   = r_sum2;
        n_prev   = r_prev;
        n_tick   = r_tick;
        terminal = 1'b0;
        res.status    = ST_PENDING;
        res.frame_len = r_count;

        if (i_word.func == FUNC_TICK) begin
            if (tick_expired) begin
                terminal   = 1'b1;
                res.status = (r_count != 10'd0) ? ST_TIMEOUT_DATA : ST_TIMEOUT_EMPTY;
            end else begin
                n_tick = tick_n[15:0];
            end
        end else begin
            n_sum2 = r_sum1;
            n_sum1 = r_sum;
            if (r_count >= HDR_COUNT) begin
                n_sum = r_sum + rx;
            end else begin
                n_hdr[r_count[1:0]] = rx;
            end
            n_prev        = rx;
            n_count       = byte_n[9:0];
            res.frame_len = byte_n[9:0];

            if (fixed_hit) begin
                terminal   = 1'b1;
                res.status = (fixed_sum == r_hdr[3]) ? ST_FIXED_OK : ST_BAD_FIXED;
            end else if (var_hit) begin
                terminal   = 1'b1;
                res.status = ST_VAR_OK;
            end else if (ovf) begin
                terminal   = 1'b1;
                res.status = ST_OVERFLOW;
            end
        end

        if (terminal) begin
            n_count = '0;
            for (int k = 0; k < HDR_BYTES; k++) begin
                n_hdr[k] = '0;
            end
            n_sum  = '0;
            n_sum1 = '0;
            n_sum2 = '0;
            n_prev = '0;
            n_tick = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int k = 0; k < HDR_BYTES; k++) begin
                r_hdr[k] <= '0;
            end
            r_sum  <= '0;
            r_sum1 <= '0;
            r_sum2 <= '0;
            r_prev <= '0;
            r_tick <= '0;
        end else if (fire) begin
            r_count <= n_count;
            r_hdr   <= n_hdr;
            r_sum   <= n_sum;
            r_sum1  <= n_sum1;
            r_sum2  <= n_sum2;
            r_prev  <= n_prev;
            r_tick  <= n_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_out_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_word <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // r_sum2 is kept for the frame state; the check reads its next value (r_sum1)
    logic unused_sum2;
    assign unused_sum2 = ^r_sum2;

`ifndef ASSERT_OFF
    a_terminal_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && (res.status != ST_PENDING) |=> (r_count == 10'd0) && (r_tick == 16'd0))
        else $error("frame state not cleared after a terminal result");

    a_byte_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && (i_word.func == FUNC_BYTE) && (res.status == ST_PENDING)
        |=> r_count == $past(r_count) + 10'd1)
        else $error("pending byte did not advance the count");

    a_fixed_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && ((r_out_word.status == ST_FIXED_OK)
                        || (r_out_word.status == ST_BAD_FIXED))
        |-> r_out_word.frame_len == 10'd5)
        else $error("fixed frame result with wrong length");

    a_empty_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_word.status == ST_TIMEOUT_EMPTY)
        |-> r_out_word.frame_len == 10'd0)
        else $error("empty timeout reported with bytes counted");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("taken word produced no result");
`endif

endmodule

`default_nettype wire

>>> rtl/ft12_frame_receiver_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: an accepted word waits in the input register, and its result is registered in
// the engine's output register and offered from there.
// Throughput: one word per cycle while results are taken. The input register holds
// one more word while a result waits; once it is full, an output stall holds the
// input in the same cycle.
// Reset (synchronous, active low) clears all frame state and the pipeline
// and loads the configuration registers with their default values.

module ft12_frame_receiver_core #(
    parameter int MAX_BYTES = 512
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire ft12_pkg::t_in_word              i_in_word,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output ft12_pkg::t_out_word                  o_out_word,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [ft12_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ft12_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ft12_pkg::*;

    t_cfg     cfg;
    logic     held_valid;
    logic     take;
    t_in_word held_word;

    ft12_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ft12_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_word  (i_in_word),
        .o_valid (held_valid),
        .i_take  (take),
        .o_word  (held_word)
    );

    ft12_frame_engine #(
        .MAX_BYTES (MAX_BYTES)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (held_valid),
        .o_take      (take),
        .i_word      (held_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire
